### sv/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Types, constants and helper functions of the bf16 scaled accumulate block.
// ----------------------------------------------------------------------------
package bsa_pkg;

    typedef struct packed {
        logic [15:0] in_value;
        logic [15:0] acc_value;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_value;
        logic        last_out;
    } t_out_item;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_ACCUM = 1'b1;

    localparam logic [31:0] F32_DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_QUIET_BIT   = 32'h0040_0000;
    localparam logic [30:0] F32_INF_MAG     = 31'h7F80_0000;

    function automatic logic f32_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic f32_is_snan(input logic [31:0] b);
        return f32_is_nan(b) && !b[22];
    endfunction

    function automatic logic f32_is_inf(input logic [31:0] b);
        return b[30:0] == F32_INF_MAG;
    endfunction

    function automatic logic f32_is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc41(input logic [40:0] v);
        logic [5:0] n;
        n = 6'd41;
        for (int i = 0; i < 41; i++) begin
            if (v[i]) begin
                n = 6'(40 - i);
            end
        end
        return n;
    endfunction

endpackage

### sv/bf16_scaled_accumulate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_scaled_accumulate_top
// Streams bf16 elements through out = acc + alpha * in, computed as one fp32
// fused multiply-add and rounded to bf16.
// ----------------------------------------------------------------------------
// A new item is accepted every cycle unless a stalled output has backed up the
// pipeline. The pipeline is the input register, then unpack and 8x24 multiply,
// align and add, leading-zero normalize, subnormal shift, fp32 round, and bf16
// round into the output register. Stages advance independently, so bubbles are
// squeezed out while the output is stalled. The user must write alpha and
// accumulate mode through the configuration port only while no item is in
// flight; the block itself does not enforce this.
module bf16_scaled_accumulate_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsa_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bsa_pkg::*;

    logic [31:0] r_scale;
    logic        r_accum;
    logic [6:1]  r_v;
    logic        r_out_vld;
    logic [7:1]  adv;

    // stage 1: input register
    t_in_item r1_in;

    // stage 2
    logic [31:0]        r2_p, r2_c, r2_sval;
    logic signed [11:0] r2_ep, r2_ec;
    logic               r2_sp, r2_sc, r2_cz, r2_spec, r2_last;

    // stage 3
    logic [40:0]        r3_s;
    logic signed [11:0] r3_es;
    logic               r3_sign, r3_spec, r3_last;
    logic [31:0]        r3_sval;

    // stage 4
    logic [40:0]        r4_n;
    logic signed [11:0] r4_t;
    logic               r4_sign, r4_z, r4_spec, r4_last;
    logic [31:0]        r4_sval;

    // stage 5
    logic [23:0]        r5_m24;
    logic               r5_g, r5_st, r5_sign, r5_z, r5_spec, r5_last;
    logic [11:0]        r5_em1;
    logic [31:0]        r5_sval;

    // stage 6
    logic [31:0]        r6_f;
    logic               r6_last;

    t_out_item r_out;

    // ---------------- handshake ----------------
    always_comb begin
        adv[7] = !r_out_vld || i_out_ready;
        for (int k = 6; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[1];
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= 32'd0;
            r_accum   <= 1'b1;
            r_v       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCALE: r_scale <= i_cfg_data;
                    CFG_ACCUM: r_accum <= i_cfg_data[0];
                    default:   r_scale <= r_scale;
                endcase
            end
            if (adv[1]) r_v[1] <= i_in_valid;
            for (int k = 2; k <= 6; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
            if (adv[7]) r_out_vld <= r_v[6];
        end
    end

    // ---------------- stage 1 -> 2: unpack, specials, multiply ----------------
    logic [15:0]        x16, c16;
    logic [31:0]        x32, c32, a32;
    logic [7:0]         mx, mxn, mc, mcn;
    logic [23:0]        ma, man;
    logic [3:0]         lzx, lzc;
    logic [4:0]         lza;
    logic signed [11:0] exn, ecn, ean;
    logic               sp, sc, bad_mul, pz, cz;
    logic               n2_spec;
    logic [31:0]        n2_sval;

    always_comb begin
        x16 = r1_in.in_value;
        c16 = r_accum ? r1_in.acc_value : 16'd0;
        x32 = {x16, 16'd0};
        c32 = {c16, 16'd0};
        a32 = r_scale;
        sp  = x16[15] ^ a32[31];
        sc  = c16[15];

        mx  = {|x16[14:7], x16[6:0]};
        lzx = lzc8(mx);
        mxn = 8'(mx << lzx);
        exn = ((x16[14:7] == 8'd0) ? -12'sd133 : ($signed({4'd0, x16[14:7]}) - 12'sd134))
              - $signed({8'd0, lzx});

        mc  = {|c16[14:7], c16[6:0]};
        lzc = lzc8(mc);
        mcn = 8'(mc << lzc);
        ecn = ((c16[14:7] == 8'd0) ? -12'sd133 : ($signed({4'd0, c16[14:7]}) - 12'sd134))
              - $signed({8'd0, lzc}) - 12'sd24;

        ma  = {|a32[30:23], a32[22:0]};
        lza = lzc24(ma);
        man = 24'(ma << lza);
        ean = ((a32[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, a32[30:23]}) - 12'sd150))
              - $signed({7'd0, lza});

        bad_mul = (f32_is_inf(x32) && f32_is_zero(a32)) ||
                  (f32_is_zero(x32) && f32_is_inf(a32));
        pz = f32_is_zero(x32) || f32_is_zero(a32);
        cz = f32_is_zero(c32);

        n2_spec = 1'b1;
        n2_sval = 32'd0;
        priority if (f32_is_snan(c32)) begin
            n2_sval = c32 | F32_QUIET_BIT;
        end else if (f32_is_snan(x32)) begin
            n2_sval = x32 | F32_QUIET_BIT;
        end else if (f32_is_snan(a32)) begin
            n2_sval = a32 | F32_QUIET_BIT;
        end else if (f32_is_nan(c32) && bad_mul) begin
            n2_sval = F32_DEFAULT_NAN;
        end else if (f32_is_nan(c32)) begin
            n2_sval = c32 | F32_QUIET_BIT;
        end else if (f32_is_nan(x32)) begin
            n2_sval = x32 | F32_QUIET_BIT;
        end else if (f32_is_nan(a32)) begin
            n2_sval = a32 | F32_QUIET_BIT;
        end else if (bad_mul) begin
            n2_sval = F32_DEFAULT_NAN;
        end else if (f32_is_inf(x32) || f32_is_inf(a32)) begin
            n2_sval = (f32_is_inf(c32) && (sc != sp)) ? F32_DEFAULT_NAN : {sp, F32_INF_MAG};
        end else if (f32_is_inf(c32)) begin
            n2_sval = c32;
        end else if (pz && cz) begin
            n2_sval = {sp & sc, 31'd0};
        end else if (pz) begin
            n2_sval = c32;
        end else begin
            n2_spec = 1'b0;
        end
    end

    // ---------------- stage 2 -> 3: align and add ----------------
    logic signed [11:0] d2, dist2, ebig;
    logic               pbig, bs, ss, sub, neg;
    logic [31:0]        big, small_op;
    logic [5:0]         amt2;
    logic [40:0]        bigw, sj;
    logic [81:0]        wide2;
    logic [41:0]        sum42;
    logic [40:0]        n3_s;
    logic               n3_sign;

    always_comb begin
        d2       = r2_ep - r2_ec;
        pbig     = r2_cz || !d2[11];
        big      = pbig ? r2_p : r2_c;
        small_op = pbig ? r2_c : r2_p;
        bs       = pbig ? r2_sp : r2_sc;
        ss       = pbig ? r2_sc : r2_sp;
        ebig     = pbig ? r2_ep : r2_ec;
        dist2    = pbig ? d2 : -d2;
        amt2     = (|dist2[11:6]) ? 6'd63 : dist2[5:0];
        bigw     = {1'b0, big, 8'd0};
        wide2    = {1'b0, small_op, 8'd0, 41'd0} >> amt2;
        sj       = wide2[81:41] | {40'd0, |wide2[40:0]};
        sub      = bs ^ ss;
        sum42    = sub ? ({1'b0, bigw} - {1'b0, sj}) : ({1'b0, bigw} + {1'b0, sj});
        neg      = sub && sum42[41];
        n3_s     = neg ? 41'(-sum42) : sum42[40:0];
        n3_sign  = (n3_s == 41'd0) ? 1'b0 : (neg ? ss : bs);
    end

    // ---------------- stage 3 -> 4: normalize ----------------
    logic [5:0]         lz3;
    logic [40:0]        n4_n;
    logic signed [11:0] n4_t;

    always_comb begin
        lz3  = lzc41(r3_s);
        n4_n = 41'(r3_s << lz3);
        n4_t = r3_es + 12'sd40 - $signed({6'd0, lz3});
    end

    // ---------------- stage 4 -> 5: subnormal shift ----------------
    logic signed [11:0] k4;
    logic [5:0]         amt4;
    logic [81:0]        wide4;
    logic [11:0]        n5_em1;
    logic               n5_st;

    always_comb begin
        k4     = (r4_t < -12'sd126) ? (-12'sd126 - r4_t) : 12'sd0;
        amt4   = (|k4[11:6]) ? 6'd63 : k4[5:0];
        wide4  = {r4_n, 41'd0} >> amt4;
        n5_st  = (|wide4[40:0]) || (|wide4[56:41]);
        n5_em1 = (k4 != 12'sd0) ? 12'd0 : 12'(r4_t + 12'sd126);
    end

    // ---------------- stage 5 -> 6: fp32 round ----------------
    logic        up5, inf5;
    logic [24:0] m25;
    logic [34:0] bits5;
    logic [31:0] n6_f;

    always_comb begin
        up5   = r5_g && (r5_st || r5_m24[0]);
        m25   = {1'b0, r5_m24} + {24'd0, up5};
        bits5 = {r5_em1, 23'd0} + {10'd0, m25};
        inf5  = (r5_em1 >= 12'd255) || (bits5 >= {4'd0, F32_INF_MAG});
        if (r5_spec) begin
            n6_f = r5_sval;
        end else if (r5_z) begin
            n6_f = 32'd0;
        end else begin
            n6_f = {r5_sign, inf5 ? F32_INF_MAG : bits5[30:0]};
        end
    end

    // ---------------- stage 6 -> out: bf16 round ----------------
    logic [32:0] sum6;
    t_out_item   n_out;

    always_comb begin
        sum6 = {1'b0, r6_f} + 33'h7FFF + {32'd0, r6_f[16]};
        n_out.out_value = f32_is_nan(r6_f) ? (r6_f[31:16] | 16'h0040) : sum6[31:16];
        n_out.last_out  = r6_last;
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (adv[1] && i_in_valid) begin
            r1_in <= i_in_data;
        end
        if (adv[2] && r_v[1]) begin
            r2_p    <= mxn * man;
            r2_ep   <= exn + ean;
            r2_c    <= {mcn, 24'd0};
            r2_ec   <= ecn;
            r2_sp   <= sp;
            r2_sc   <= sc;
            r2_cz   <= cz;
            r2_spec <= n2_spec;
            r2_sval <= n2_sval;
            r2_last <= r1_in.last_in;
        end
        if (adv[3] && r_v[2]) begin
            r3_s    <= n3_s;
            r3_es   <= ebig - 12'sd8;
            r3_sign <= n3_sign;
            r3_spec <= r2_spec;
            r3_sval <= r2_sval;
            r3_last <= r2_last;
        end
        if (adv[4] && r_v[3]) begin
            r4_n    <= n4_n;
            r4_t    <= n4_t;
            r4_sign <= r3_sign;
            r4_z    <= (r3_s == 41'd0);
            r4_spec <= r3_spec;
            r4_sval <= r3_sval;
            r4_last <= r3_last;
        end
        if (adv[5] && r_v[4]) begin
            r5_m24  <= wide4[81:58];
            r5_g    <= wide4[57];
            r5_st   <= n5_st;
            r5_em1  <= n5_em1;
            r5_sign <= r4_sign;
            r5_z    <= r4_z;
            r5_spec <= r4_spec;
            r5_sval <= r4_sval;
            r5_last <= r4_last;
        end
        if (adv[6] && r_v[5]) begin
            r6_f    <= n6_f;
            r6_last <= r5_last;
        end
        if (adv[7] && r_v[6]) begin
            r_out <= n_out;
        end
    end

    // ---------------- assertions ----------------
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v[1])
        else $error("accepted item did not enter stage 1");

    a_product_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !r2_spec |-> (r2_p[31] || r2_p[30]))
        else $error("product not normalized");

    a_sum_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && !r4_z |-> r4_n[40])
        else $error("sum not normalized");

    a_nan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] && adv[7] && f32_is_nan(r6_f) |=>
            (o_out_data.out_value[14:7] == 8'hFF) && o_out_data.out_value[6])
        else $error("nan result not quiet");

endmodule

### tb/bf16_scaled_accumulate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_scaled_accumulate_checker
// Watches the config, input and output channels, predicts each bf16 result
// from the element and the current alpha and mode, and compares in order.
// ----------------------------------------------------------------------------
module bf16_scaled_accumulate_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bsa_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bsa_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    import bsa_pkg::*;

    localparam logic [31:0] DEF_NAN = 32'h7FC0_0000;
    localparam logic [31:0] QBIT    = 32'h0040_0000;
    localparam logic [31:0] INF     = 32'h7F80_0000;

    logic [31:0] alpha_bits;
    logic        accum_on;
    t_out_item   expected_q[$];

    function automatic bit is_nan(logic [31:0] b);
        return b[30:0] > INF[30:0];
    endfunction
    function automatic bit is_snan(logic [31:0] b);
        return is_nan(b) && !b[22];
    endfunction
    function automatic bit is_inf(logic [31:0] b);
        return b[30:0] == INF[30:0];
    endfunction
    function automatic bit is_zero(logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    function automatic int msb_pos(logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] jam_shift(logic [63:0] v, int d);
        logic [63:0] mask;
        if (d <= 0) return v;
        if (d >= 64) return (v != 0) ? 64'd1 : 64'd0;
        mask = (64'd1 << d) - 64'd1;
        return (v >> d) | ((v & mask) != 0 ? 64'd1 : 64'd0);
    endfunction

    function automatic logic [31:0] round_f32(logic s, logic [63:0] r, int e);
        int          p;
        int          lsb;
        int          sh;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        p = msb_pos(r);
        lsb = p + e - 23;
        if (lsb < -149) lsb = -149;
        sh = lsb - e;
        if (sh <= 0) begin
            m = r << (-sh);
        end else if (sh > 64) begin
            m = 0;
        end else begin
            if (sh == 64) begin
                m = 0;
                rem = r;
            end else begin
                m = r >> sh;
                rem = r & ((64'd1 << sh) - 64'd1);
            end
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m = m + 1;
        end
        if (lsb + 149 >= 255) return {s, INF[30:0]};
        bits = (64'(lsb + 149) << 23) + m;
        if (bits >= 64'(INF)) return {s, INF[30:0]};
        return {s, bits[30:0]};
    endfunction

    function automatic void split_f32(logic [31:0] b, output logic [63:0] m, output int e);
        if (b[30:23] == 0) begin
            m = 64'(b[22:0]);
            e = -149;
        end else begin
            m = 64'({1'b1, b[22:0]});
            e = int'(b[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] fma_f32(logic [31:0] c, logic [31:0] x, logic [31:0] a);
        logic        sp;
        logic        sc;
        logic        bad;
        logic [63:0] mx, ma, mc, mp, np, nc, big, sml, r;
        int          ex, ea, ec, ep, enp, enc, bexp;
        logic        bs, ss, rs;
        sp = x[31] ^ a[31];
        sc = c[31];
        bad = (is_inf(x) && is_zero(a)) || (is_zero(x) && is_inf(a));
        if (is_snan(c)) return c | QBIT;
        if (is_snan(x)) return x | QBIT;
        if (is_snan(a)) return a | QBIT;
        if (is_nan(c) && bad) return DEF_NAN;
        if (is_nan(c)) return c | QBIT;
        if (is_nan(x)) return x | QBIT;
        if (is_nan(a)) return a | QBIT;
        if (bad) return DEF_NAN;
        if (is_inf(x) || is_inf(a)) begin
            if (is_inf(c) && sc != sp) return DEF_NAN;
            return {sp, INF[30:0]};
        end
        if (is_inf(c)) return c;
        split_f32(c, mc, ec);
        split_f32(x, mx, ex);
        split_f32(a, ma, ea);
        mp = mx * ma;
        ep = ex + ea;
        if (mp == 0 && mc == 0) return {sp & sc, 31'd0};
        if (mp == 0) return c;
        if (mc == 0) return round_f32(sp, mp, ep);
        np = mp << (61 - msb_pos(mp));
        enp = ep - (61 - msb_pos(mp));
        nc = mc << (61 - msb_pos(mc));
        enc = ec - (61 - msb_pos(mc));
        if (enp >= enc) begin
            big = np; bexp = enp; bs = sp;
            sml = jam_shift(nc, enp - enc); ss = sc;
        end else begin
            big = nc; bexp = enc; bs = sc;
            sml = jam_shift(np, enc - enp); ss = sp;
        end
        if (bs == ss) begin
            r = big + sml; rs = bs;
        end else if (big >= sml) begin
            r = big - sml; rs = bs;
        end else begin
            r = sml - big; rs = ss;
        end
        if (r == 0) return 32'd0;
        return round_f32(rs, r, bexp);
    endfunction

    function automatic logic [15:0] narrow_bf16(logic [31:0] f);
        logic [31:0] t;
        if (is_nan(f)) return f[31:16] | 16'h0040;
        t = f + 32'h7FFF + 32'(f[16]);
        return t[31:16];
    endfunction

    function automatic t_out_item scaled_sum(t_in_item it);
        t_out_item   o;
        logic [31:0] addend;
        addend = accum_on ? {it.acc_value, 16'h0} : 32'h0;
        o.out_value = narrow_bf16(fma_f32(addend, {it.in_value, 16'h0}, alpha_bits));
        o.last_out = it.last_in;
        return o;
    endfunction

    assign o_pending = expected_q.size();

    always_ff @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            alpha_bits <= 32'h0;
            accum_on <= 1'b1;
            expected_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SCALE) alpha_bits <= i_cfg_data;
                else accum_on <= i_cfg_data[0];
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected item out %h/%0d", i_out_data.out_value,
                                 i_out_data.last_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h/%0d got %h/%0d",
                                     want.out_value, want.last_out,
                                     i_out_data.out_value, i_out_data.last_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_q.push_back(scaled_sum(i_in_data));
        end
    end
endmodule

### tb/bf16_scaled_accumulate_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_scaled_accumulate_top_test
// Drives bf16 elements through the block under several alpha and mode
// settings with bursty input and random output stalls; a checker compares.
// ----------------------------------------------------------------------------
module bf16_scaled_accumulate_top_test;
    import bsa_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready = 1'b1;
    t_out_item out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [31:0] cfg_data;
    int        fail_count;
    int        pending;
    int        result_count;
    int        idle_cycles = 0;
    int        stall_mode = 0;
    int        phases_done;

    localparam int WATCHDOG = 20000;

    bf16_scaled_accumulate_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    bf16_scaled_accumulate_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // receiver stall pattern, changes style now and then
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress, %0d items still expected", pending);
            $display("bf16_scaled_accumulate_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_item(input logic [15:0] x, input logic [15:0] c, input logic lst);
        in_valid <= 1'b1;
        in_data <= '{in_value: x, acc_value: c, last_in: lst};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_bf16();
        case ($urandom_range(0, 9))
            0: return {1'($urandom), 8'hFF, 7'($urandom)};
            1: return {1'($urandom), 8'h00, 7'($urandom)};
            2: return {1'($urandom), 15'h7F80};
            3: return {1'($urandom), 15'h0};
            4: return {1'($urandom), 8'($urandom_range(110, 145)), 7'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(0, 7))
            0: return {1'($urandom), 8'hFF, 23'($urandom)};
            1: return {1'($urandom), 8'h00, 23'($urandom)};
            2: return {1'($urandom), 31'h7F80_0000};
            3: return {1'($urandom), 8'($urandom_range(120, 135)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_item(pick_bf16(), pick_bf16(), ($urandom_range(0, 15) == 0));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] dir_x[13];
        logic [15:0] dir_c[13];
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCALE;
        cfg_data = '0;
        phases_done = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: alpha zero, accumulate on
        dir_x = '{16'h3F80, 16'h7F80, 16'hFF80, 16'h7F81, 16'h7FC1, 16'h0001, 16'h8000,
                  16'h7F7F, 16'h0000, 16'h3F80, 16'h7F80, 16'hFFFF, 16'h0080};
        dir_c = '{16'h4000, 16'h0000, 16'h7F80, 16'h3F80, 16'h7F82, 16'h8001, 16'h8000,
                  16'h7F7F, 16'h7FC0, 16'hBF80, 16'hFF80, 16'h0000, 16'h8080};
        foreach (dir_x[i]) send_item(dir_x[i], dir_c[i], i[0]);
        in_valid <= 1'b0;
        drain_pipe();

        // alpha one, infinity, max, signaling NaN; covers overflow and cancellation
        write_reg(CFG_SCALE, 32'h3F80_0000);
        foreach (dir_x[i]) send_item(dir_x[i], dir_c[i], 1'b1);
        in_valid <= 1'b0;
        drain_pipe();
        write_reg(CFG_SCALE, 32'h7F80_0000);
        foreach (dir_x[i]) send_item(dir_x[i], dir_c[i], 1'b0);
        in_valid <= 1'b0;
        drain_pipe();
        write_reg(CFG_SCALE, 32'h7F7F_FFFF);
        write_reg(CFG_ACCUM, 32'h0);
        foreach (dir_x[i]) send_item(dir_x[i], dir_c[i], 1'b1);
        in_valid <= 1'b0;
        drain_pipe();
        write_reg(CFG_SCALE, 32'hFF80_0001);
        send_item(16'h3F80, 16'h3F80, 1'b0);
        in_valid <= 1'b0;
        drain_pipe();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_SCALE, pick_alpha());
            write_reg(CFG_ACCUM, (ph % 3 == 2) ? 32'h0 : 32'h1);
            random_burst(150);
            drain_pipe();
            phases_done++;
        end

        $display("covered directed special cases and %0d random phases, %0d results checked",
                 phases_done, result_count);
        if (fail_count == 0) begin
            $display("bf16_scaled_accumulate_top verification clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("bf16_scaled_accumulate_top verification failed");
        end
        $finish;
    end
endmodule

### files.f
sv/bsa_pkg.sv
sv/bf16_scaled_accumulate_top.sv
tb/bf16_scaled_accumulate_checker.sv
tb/bf16_scaled_accumulate_top_test.sv
